// File: hw/rtl/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform unit.
// Used by the matrix store, the row lanes and the top level.
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned DIM     = 4;
  localparam int unsigned PROD_W  = 2 * ENTRY_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SUM_W   = ACC_W - FRAC_W;

  localparam logic [ENTRY_W-1:0] Q_ONE = 32'h0001_0000;

  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSFORM = 1'b1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t [DIM*DIM-1:0] matrix_t;
  typedef entry_t [DIM-1:0] vec_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } lane_ctrl_t;

endpackage

// File: hw/rtl/mvt_matrix_store.sv
// Register file holding the 4x4 Q16.16 matrix, row-major, reset to identity.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_matrix_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_row,
  input  logic [1:0]        wr_col,
  input  mvt_pkg::entry_t   wr_data,
  output mvt_pkg::matrix_t  mat
);

  mvt_pkg::matrix_t mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mvt_pkg::DIM * mvt_pkg::DIM; i++) begin
        mat_r[i] <= ((i % mvt_pkg::DIM) == (i / mvt_pkg::DIM)) ? mvt_pkg::Q_ONE : '0;
      end
    end else if (wr_en) begin
      mat_r[{wr_row, wr_col}] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

// File: hw/rtl/mvt_row_lane.sv
// One row lane: four multipliers, an exact row sum with floor shift, and saturation.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_row_lane (
  input  logic                clk,
  input  mvt_pkg::lane_ctrl_t ctrl,
  input  mvt_pkg::vec_t       row_entries,
  input  mvt_pkg::vec_t       vec,
  output mvt_pkg::entry_t     result
);

  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_MAX = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_MIN = -50'sh0_0000_8000_0000;

  logic signed [mvt_pkg::PROD_W-1:0] prod_nxt [mvt_pkg::DIM];
  logic signed [mvt_pkg::PROD_W-1:0] prod_r   [mvt_pkg::DIM];
  logic signed [mvt_pkg::ACC_W-1:0]  acc;
  logic signed [mvt_pkg::SUM_W-1:0]  sum_nxt;
  logic signed [mvt_pkg::SUM_W-1:0]  sum_r;

  always_comb begin
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      prod_nxt[c] = row_entries[c] * vec[c];
    end
  end

  assign acc = mvt_pkg::ACC_W'(prod_r[0]) + mvt_pkg::ACC_W'(prod_r[1])
             + mvt_pkg::ACC_W'(prod_r[2]) + mvt_pkg::ACC_W'(prod_r[3]);
  assign sum_nxt = acc[mvt_pkg::ACC_W-1:mvt_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
    if (ctrl.load_sum) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    if (sum_r > SAT_MAX) begin
      result = 32'sh7FFF_FFFF;
    end else if (sum_r < SAT_MIN) begin
      result = 32'sh8000_0000;
    end else begin
      result = sum_r[mvt_pkg::ENTRY_W-1:0];
    end
  end

endmodule

// File: hw/rtl/matrix_vector_transform_4x4_unit.sv
// 4x4 matrix-vector transform unit, Q16.16. A transform beat passes through four row lanes of
// four 32x32 multipliers each and their product registers, followed by a sum stage and the
// output register; one beat is taken every cycle while the output is not stalled.
// A write beat updates the matrix at its edge, is seen by the next beat, gives no result.
// Reset (synchronous, active low) loads the identity matrix and empties the pipeline.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // row[1:0], col[3:2], entry_value[35:4], in_x[67:36], in_y[99:68],
  // in_z[131:100], in_w[163:132], zeros[167:164]
  input  logic [167:0]  in_tdata,
  // req_type[0]
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [127:0]  out_tdata
);

  logic                 s1_en, s2_en, out_en;
  logic                 s1_v_r, s1_v_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 in_acc;
  logic                 wr_en;
  mvt_pkg::lane_ctrl_t  ctrl;
  mvt_pkg::matrix_t     mat;
  mvt_pkg::vec_t        vec;
  mvt_pkg::vec_t        lane_res;
  mvt_pkg::vec_t        out_r;

  assign out_en = !out_v_r || out_tready;
  assign s2_en  = !s2_v_r || out_en;
  assign s1_en  = !s1_v_r || s2_en;

  assign in_tready = s1_en;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (in_tuser == mvt_pkg::REQ_WRITE);

  assign vec[0] = in_tdata[67:36];
  assign vec[1] = in_tdata[99:68];
  assign vec[2] = in_tdata[131:100];
  assign vec[3] = in_tdata[163:132];

  assign ctrl.load_prod = s1_en;
  assign ctrl.load_sum  = s2_en;

  mvt_matrix_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_row  (in_tdata[1:0]),
    .wr_col  (in_tdata[3:2]),
    .wr_data (in_tdata[35:4]),
    .mat     (mat)
  );

  for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_lane
    mvt_row_lane u_lane (
      .clk         (clk),
      .ctrl        (ctrl),
      .row_entries (mat[r*mvt_pkg::DIM +: mvt_pkg::DIM]),
      .vec         (vec),
      .result      (lane_res[r])
    );
  end

  assign s1_v_nxt  = s1_en ? (in_tvalid && (in_tuser == mvt_pkg::REQ_TRANSFORM)) : s1_v_r;
  assign s2_v_nxt  = s2_en ? s1_v_r : s2_v_r;
  assign out_v_nxt = out_en ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r <= lane_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while the pipeline is full and stalled");

  a_transform_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == mvt_pkg::REQ_TRANSFORM)) |=> s1_v_r)
    else $error("accepted transform beat did not enter the lanes");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == mvt_pkg::REQ_WRITE) && !s1_v_r) |=> (!s1_v_r))
    else $error("write beat entered the lanes");

  a_write_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == mvt_pkg::REQ_WRITE))
      |=> (mat[{$past(in_tdata[1:0]), $past(in_tdata[3:2])}] == $past(in_tdata[35:4])))
    else $error("matrix entry not updated by write beat");

endmodule

// File: dv/matrix_vector_transform_4x4_unit_tb.sv
// Self-checking testbench for the 4x4 matrix-vector transform unit (Q16.16).
// Drives write and transform beats, predicts each transform from its own copy of the matrix
// and checks every result beat; depends on mvt_pkg and matrix_vector_transform_4x4_unit.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_unit_tb;

  typedef struct {
    logic            req;
    logic [1:0]      row;
    logic [1:0]      col;
    mvt_pkg::entry_t value;
    mvt_pkg::vec_t   vec;
  } mvt_req_t;

  localparam int LONG_HOLD = 300;
  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_HI =
    {{(mvt_pkg::SUM_W-mvt_pkg::ENTRY_W+1){1'b0}}, {(mvt_pkg::ENTRY_W-1){1'b1}}};
  localparam logic signed [mvt_pkg::SUM_W-1:0] SAT_LO =
    {{(mvt_pkg::SUM_W-mvt_pkg::ENTRY_W+1){1'b1}}, {(mvt_pkg::ENTRY_W-1){1'b0}}};

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [167:0]  in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [127:0]  out_tdata;

  mvt_req_t          request_beats[$];
  mvt_pkg::vec_t     expected_vectors[$];
  mvt_pkg::matrix_t  matrix_copy;
  bit        in_fire = 1'b0;
  bit        out_fire = 1'b0;
  int        mismatch_count = 0;
  int        src_gap_max = 0;
  int        sink_stall_max = 0;
  int        hold_requests = 0;

  matrix_vector_transform_4x4_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic mvt_pkg::entry_t dot_row(int r, mvt_pkg::vec_t v);
    logic signed [mvt_pkg::ACC_W-1:0] acc;
    logic signed [mvt_pkg::ACC_W-1:0] a;
    logic signed [mvt_pkg::ACC_W-1:0] b;
    logic signed [mvt_pkg::SUM_W-1:0] shifted;
    acc = '0;
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      a = $signed(matrix_copy[r*mvt_pkg::DIM+c]);
      b = $signed(v[c]);
      acc += a * b;
    end
    shifted = acc >>> mvt_pkg::FRAC_W;
    if (shifted > SAT_HI) return 32'h7FFF_FFFF;
    if (shifted < SAT_LO) return 32'h8000_0000;
    return shifted[mvt_pkg::ENTRY_W-1:0];
  endfunction

  function automatic mvt_pkg::vec_t transform_vector(mvt_pkg::vec_t v);
    mvt_pkg::vec_t res;
    for (int r = 0; r < mvt_pkg::DIM; r++) res[r] = dot_row(r, v);
    return res;
  endfunction

  function automatic mvt_pkg::entry_t rand_q();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return r;
      default: return {{13{r[18]}}, r[18:0]};
    endcase
  endfunction

  task automatic add_write(logic [1:0] row, logic [1:0] col, mvt_pkg::entry_t value);
    mvt_req_t b;
    b.req = mvt_pkg::REQ_WRITE;
    b.row = row;
    b.col = col;
    b.value = value;
    b.vec = {$urandom, $urandom, $urandom, $urandom};
    request_beats.push_back(b);
  endtask

  task automatic add_transform(mvt_pkg::entry_t x, mvt_pkg::entry_t y,
                               mvt_pkg::entry_t z, mvt_pkg::entry_t w);
    mvt_req_t b;
    b.req = mvt_pkg::REQ_TRANSFORM;
    b.row = 2'($urandom_range(0, 3));
    b.col = 2'($urandom_range(0, 3));
    b.value = $urandom;
    b.vec = {w, z, y, x};
    request_beats.push_back(b);
  endtask

  task automatic wait_drained();
    while (request_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_vectors.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int gap_max, int stall_max, bit long_hold);
    src_gap_max = gap_max;
    sink_stall_max = stall_max;
    if (long_hold) hold_requests++;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        add_write(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_q());
      else
        add_transform(rand_q(), rand_q(), rand_q(), rand_q());
    end
    wait_drained();
  endtask

  // Sender: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin
    int gap_left;
    mvt_req_t b;
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_beats.size() > 0) begin
        b = request_beats.pop_front();
        in_tuser <= b.req;
        in_tdata <= {4'b0000, b.vec, b.value, b.col, b.row};
        in_tvalid <= 1'b1;
        gap_left = $urandom_range(0, src_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a random stall after each result beat, plus the occasional long hold-off.
  always @(negedge clk) begin
    int stall_left;
    int hold_left;
    int hold_served;
    if (rst_n) begin
      if (hold_served != hold_requests) begin
        hold_left = LONG_HOLD;
        hold_served = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (out_fire) stall_left = $urandom_range(0, sink_stall_max);
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    mvt_pkg::vec_t exp_v;
    mvt_pkg::vec_t act_v;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      if (in_tuser == mvt_pkg::REQ_WRITE)
        matrix_copy[{in_tdata[1:0], in_tdata[3:2]}] = in_tdata[35:4];
      else
        expected_vectors.push_back(transform_vector(in_tdata[163:36]));
    end
    if (out_fire) begin
      act_v = out_tdata;
      if (expected_vectors.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, act_v);
        mismatch_count++;
      end else begin
        exp_v = expected_vectors.pop_front();
        for (int k = 0; k < mvt_pkg::DIM; k++) begin
          if (act_v[k] !== exp_v[k]) begin
            $display("%0t: component %0d expected %h actual %h", $time, k, exp_v[k], act_v[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < mvt_pkg::DIM*mvt_pkg::DIM; i++)
      matrix_copy[i] = ((i % mvt_pkg::DIM) == (i / mvt_pkg::DIM)) ? mvt_pkg::Q_ONE : '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    src_gap_max = 2;
    sink_stall_max = 2;
    add_transform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    for (int c = 0; c < mvt_pkg::DIM; c++) add_write(2'd0, 2'(c), 32'h7FFF_FFFF);
    for (int c = 0; c < mvt_pkg::DIM; c++) add_write(2'd3, 2'(c), 32'h8000_0000);
    add_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_write(2'd1, 2'd1, 32'hFFFF_FFFF);
    add_transform(32'h0001_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    add_write(2'd2, 2'd2, 32'h0000_0000);
    add_write(2'd1, 2'd2, 32'h0002_8000);
    add_transform(32'hFFFF_0000, 32'h0003_0000, 32'h7FFF_FFFF, 32'hFFFE_8000);
    add_write(2'd2, 2'd0, 32'hFFFF_8000);
    add_transform(32'h0000_0003, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    wait_drained();

    run_phase(170, 0, 0, 1'b0);
    run_phase(170, 8, 8, 1'b0);
    run_phase(170, 0, 0, 1'b1);
    run_phase(170, 8, 0, 1'b0);
    run_phase(170, 0, 8, 1'b0);

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_vectors.size() == 0) begin
      $display("matrix_vector_transform_4x4_unit_tb OK");
    end else begin
      $display("matrix_vector_transform_4x4_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_vectors.size());
    $display("matrix_vector_transform_4x4_unit_tb NOT OK");
    $finish;
  end

endmodule

// File: matrix_vector_transform_4x4_unit.f
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_matrix_store.sv
hw/rtl/mvt_row_lane.sv
hw/rtl/matrix_vector_transform_4x4_unit.sv
dv/matrix_vector_transform_4x4_unit_tb.sv
